// ----- src/qalu_pkg.sv -----
// ----------------------------------------------------------------------------
// Quaternion ALU package
// Shared types, codes and helpers of the quaternion arithmetic unit.
// ----------------------------------------------------------------------------
package qalu_pkg;

   localparam int FRAC_BITS_DEF   = 16;
   localparam int QUEUE_DEPTH_DEF = 4;
   localparam int COMP_W          = 66;
   localparam int SQ_W            = 65;
   localparam int SCALAR_W        = 50;
   localparam logic [SCALAR_W-1:0] SCALAR_MAX = '1;
   localparam logic signed [67:0] SAT_HI = 68'sh0_0000_0000_7FFF_FFFF;
   localparam logic signed [67:0] SAT_LO = -68'sh0_0000_0000_8000_0000;

   typedef enum logic [3:0] {
      ACT_ADD    = 4'd0,
      ACT_SUB    = 4'd1,
      ACT_MUL    = 4'd2,
      ACT_DIV    = 4'd3,
      ACT_NEG    = 4'd4,
      ACT_CONJ   = 4'd5,
      ACT_INV    = 4'd6,
      ACT_SQNORM = 4'd7,
      ACT_NORM   = 4'd8,
      ACT_EQ     = 4'd9,
      ACT_NE     = 4'd10,
      ACT_LT     = 4'd11,
      ACT_LE     = 4'd12,
      ACT_GT     = 4'd13,
      ACT_GE     = 4'd14
   } action_type;

   typedef enum logic [2:0] {
      KIND_SIMPLE,
      KIND_MUL,
      KIND_DIV,
      KIND_INV,
      KIND_SQN,
      KIND_NORM,
      KIND_CMP
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_ZDIV = 2'd1,
      ST_SAT  = 2'd2
   } status_type;

   typedef struct packed {
      action_type       action;
      kind_type         kind;
      logic [3:0][31:0] a;
      logic [3:0][31:0] b;
      logic [31:0]      radius;
   } item_type;

   typedef struct packed {
      logic [3:0][31:0]    r;
      logic [SCALAR_W-1:0] scalar;
      logic                flag;
      status_type          status;
   } result_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic busy;
      logic pop;
   } back_status_type;

   typedef struct packed {
      logic [31:0] val;
      logic        ovf;
   } sat_type;

   function automatic sat_type sat32(input logic signed [67:0] v);
      sat_type r;
      if (v > SAT_HI) begin
         r.val = 32'h7FFF_FFFF;
         r.ovf = 1'b1;
      end else if (v < SAT_LO) begin
         r.val = 32'h8000_0000;
         r.ovf = 1'b1;
      end else begin
         r.val = v[31:0];
         r.ovf = 1'b0;
      end
      return r;
   endfunction

endpackage

// ----- src/qalu_front.sv -----
// ----------------------------------------------------------------------------
// Quaternion ALU front end
// Accepts request transfers, decodes the operation and tags each item with
// the kind of work the back end must do.
// ----------------------------------------------------------------------------
module qalu_front (
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [3:0]                 req_tuser,  // action
   input  logic [287:0]               req_tdata,  // a_w a_x a_y a_z b_w b_x b_y b_z radius
   input  qalu_pkg::queue_status_type q_st,
   output logic                       q_push,
   output qalu_pkg::item_type         q_item
);
   import qalu_pkg::*;

   action_type act;

   assign act        = action_type'(req_tuser);
   assign req_tready = !q_st.full;
   assign q_push     = req_tvalid && !q_st.full;

   always_comb begin
      q_item.action = act;
      q_item.a      = req_tdata[127:0];
      q_item.b      = req_tdata[255:128];
      q_item.radius = req_tdata[287:256];
      unique case (act) inside
         ACT_MUL:                         q_item.kind = KIND_MUL;
         ACT_DIV:                         q_item.kind = KIND_DIV;
         ACT_INV:                         q_item.kind = KIND_INV;
         ACT_SQNORM:                      q_item.kind = KIND_SQN;
         ACT_NORM:                        q_item.kind = KIND_NORM;
         ACT_LT, ACT_LE, ACT_GT, ACT_GE:  q_item.kind = KIND_CMP;
         default:                         q_item.kind = KIND_SIMPLE;
      endcase
   end

endmodule

// ----- src/qalu_queue.sv -----
// ----------------------------------------------------------------------------
// Quaternion ALU item queue
// Small first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module qalu_queue #(
   parameter int DEPTH = qalu_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  qalu_pkg::item_type         item_in,
   input  logic                       pop,
   output qalu_pkg::item_type         item_out,
   output qalu_pkg::queue_status_type q_st
);
   import qalu_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   item_type        mem_ff [DEPTH];
   logic [PW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]   cnt_ff, cnt_in;

   assign q_st.full  = cnt_ff == CW'(DEPTH);
   assign q_st.empty = cnt_ff == '0;
   assign item_out   = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= item_in;
      end
   end

endmodule

// ----- src/qalu_back.sv -----
// ----------------------------------------------------------------------------
// Quaternion ALU back end
// Executes queued items: combinational lane operations, a four-lane multiplier
// for products and norms, a bit-serial divider and a bit-serial square root.
// ----------------------------------------------------------------------------
module qalu_back #(
   parameter int FRAC_BITS = qalu_pkg::FRAC_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  qalu_pkg::item_type         q_item,
   input  qalu_pkg::queue_status_type q_st,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output qalu_pkg::result_type       rsp_res,
   output qalu_pkg::back_status_type  st
);
   import qalu_pkg::*;

   localparam int MAG_W = COMP_W + FRAC_BITS;
   localparam int DW    = SQ_W + 32;
   localparam logic signed [32:0] ONE_Q  = 33'(65'd1 << FRAC_BITS);
   localparam logic signed [67:0] HALF_C = 68'(68'd1 << (FRAC_BITS - 1));

   typedef enum logic [2:0] {
      S_IDLE, S_MULT, S_EVAL, S_SQRT, S_DLOAD, S_DITER, S_DDONE, S_FIN
   } state_type;

   typedef enum logic [2:0] {
      TGT_C0, TGT_C1, TGT_C2, TGT_C3, TGT_S, TGT_R2
   } tgt_type;

   state_type                 state_ff, state_in;
   item_type                  item_ff, item_in;
   logic [2:0]                ph_ff, ph_in;
   logic signed [COMP_W-1:0]  prod_ff [4], prod_in [4];
   logic [3:0]                neg_ff, neg_in;
   tgt_type                   tgt_ff, tgt_in;
   logic                      pvld_ff, pvld_in;
   logic signed [COMP_W-1:0]  c_ff [4], c_in [4];
   logic [SQ_W-1:0]           s_ff, s_in;
   logic [63:0]               r2_ff, r2_in;
   logic [3:0][31:0]          res_r_ff, res_r_in;
   logic [SCALAR_W-1:0]       res_scalar_ff, res_scalar_in;
   logic                      res_flag_ff, res_flag_in;
   status_type                res_status_ff, res_status_in;
   logic [63:0]               sq_val_ff, sq_val_in;
   logic [33:0]               sq_rem_ff, sq_rem_in;
   logic [31:0]               sq_res_ff, sq_res_in;
   logic [4:0]                cnt_ff, cnt_in;
   logic [1:0]                k_ff, k_in;
   logic [SQ_W-1:0]           drem_ff, drem_in;
   logic [31:0]               dlo_ff, dlo_in;
   logic                      dneg_ff, dneg_in;
   logic                      out_vld_ff, out_vld_in;
   result_type                out_ff, out_in;

   logic signed [32:0]        hp [4], hq [4], dq [4], aq [4];
   logic signed [32:0]        mx [4], my [4];
   logic [3:0]                mneg;
   tgt_type                   mtgt;
   logic                      mvld;
   logic [2:0]                nph;
   logic [1:0]                hk;
   logic                      ham;
   logic signed [67:0]        acc;
   result_type                simple_res;
   logic signed [32:0]        lane_v [4];
   sat_type                   lane_s [4];
   logic signed [67:0]        rnd_t [4];
   sat_type                   rnd_s [4];
   logic [SQ_W:0]             sqn_t;
   logic [SQ_W:0]             sqn_v;
   logic                      cmp_ge, cmp_le, cmp_flag;
   logic [34:0]               sq_rem2, sq_trial;
   logic [COMP_W-1:0]         cur_c;
   logic [SQ_W-1:0]           mag_c;
   logic [MAG_W-1:0]          mag;
   logic [DW-1:0]             mag_ext, limit;
   logic [SQ_W:0]             dt;
   logic signed [67:0]        qv;
   sat_type                   q_s;
   logic                      out_free;

   assign out_free  = !out_vld_ff || rsp_ready;
   assign rsp_valid = out_vld_ff;
   assign rsp_res   = out_ff;
   assign st.busy   = state_ff != S_IDLE;
   assign st.pop    = q_pop;

   // Multiplier operand selection, lane products and accumulation.
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         aq[j] = 33'($signed(item_ff.a[j]));
         dq[j] = (item_ff.kind == KIND_INV) ? aq[j] : 33'($signed(item_ff.b[j]));
         hp[j] = (item_ff.kind == KIND_INV) ? ((j == 0) ? ONE_Q : '0) : aq[j];
         if (item_ff.kind == KIND_MUL) begin
            hq[j] = 33'($signed(item_ff.b[j]));
         end else begin
            hq[j] = (j == 0) ? dq[j] : -dq[j];
         end
      end
      nph  = 3'd2;
      ham  = 1'b0;
      hk   = ph_ff[1:0];
      mtgt = TGT_S;
      mx   = dq;
      my   = dq;
      mneg = 4'b0000;
      unique case (item_ff.kind)
         KIND_MUL: begin
            nph = 3'd4;
            ham = 1'b1;
         end
         KIND_DIV, KIND_INV: begin
            nph = 3'd5;
            ham = ph_ff != 3'd0;
            hk  = 2'(ph_ff - 3'd1);
         end
         default: begin
            mx = aq;
            my = aq;
            if (ph_ff != 3'd0) begin
               mtgt = TGT_R2;
               mx   = '{33'($signed(item_ff.radius)), '0, '0, '0};
               my   = mx;
            end
         end
      endcase
      if (ham) begin
         mtgt = tgt_type'({1'b0, hk});
         unique case (hk)
            2'd0: begin
               mx   = '{hp[0], hp[1], hp[2], hp[3]};
               my   = '{hq[0], hq[1], hq[2], hq[3]};
               mneg = 4'b1110;
            end
            2'd1: begin
               mx   = '{hp[0], hp[1], hp[2], hp[3]};
               my   = '{hq[1], hq[0], hq[3], hq[2]};
               mneg = 4'b1000;
            end
            2'd2: begin
               mx   = '{hp[0], hp[2], hp[3], hp[1]};
               my   = '{hq[2], hq[0], hq[1], hq[3]};
               mneg = 4'b1000;
            end
            default: begin
               mx   = '{hp[0], hp[3], hp[1], hp[2]};
               my   = '{hq[3], hq[0], hq[2], hq[1]};
               mneg = 4'b1000;
            end
         endcase
      end
      mvld = (state_ff == S_MULT) && (ph_ff < nph);
      for (int j = 0; j < 4; j++) begin
         prod_in[j] = mx[j] * my[j];
      end
      acc = '0;
      for (int j = 0; j < 4; j++) begin
         if (neg_ff[j]) begin
            acc = acc - 68'(prod_ff[j]);
         end else begin
            acc = acc + 68'(prod_ff[j]);
         end
      end
   end

   // Combinational lane operations straight from the queue head.
   always_comb begin
      simple_res = '0;
      for (int j = 0; j < 4; j++) begin
         unique case (q_item.action)
            ACT_ADD:  lane_v[j] = 33'($signed(q_item.a[j])) + 33'($signed(q_item.b[j]));
            ACT_SUB:  lane_v[j] = 33'($signed(q_item.a[j])) - 33'($signed(q_item.b[j]));
            ACT_CONJ: lane_v[j] = (j == 0) ? 33'($signed(q_item.a[j]))
                                           : -33'($signed(q_item.a[j]));
            default:  lane_v[j] = -33'($signed(q_item.a[j]));
         endcase
         lane_s[j] = sat32(68'(lane_v[j]));
      end
      unique case (q_item.action) inside
         ACT_ADD, ACT_SUB, ACT_NEG, ACT_CONJ: begin
            for (int j = 0; j < 4; j++) begin
               simple_res.r[j] = lane_s[j].val;
               if (lane_s[j].ovf) begin
                  simple_res.status = ST_SAT;
               end
            end
         end
         ACT_EQ: simple_res.flag = q_item.a == q_item.b;
         ACT_NE: simple_res.flag = q_item.a != q_item.b;
         default: ;
      endcase
   end

   // Result evaluation after the multiplier pass, and step terms for the square root and divider.
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         rnd_t[j] = 68'(c_ff[j]) + HALF_C;
         rnd_s[j] = sat32(rnd_t[j] >>> FRAC_BITS);
      end
      sqn_t  = {1'b0, s_ff} + (SQ_W + 1)'(HALF_C);
      sqn_v  = sqn_t >> FRAC_BITS;
      cmp_ge = s_ff >= SQ_W'(r2_ff);
      cmp_le = SQ_W'(r2_ff) >= s_ff;
      unique case (item_ff.action)
         ACT_LT:  cmp_flag = !cmp_ge;
         ACT_LE:  cmp_flag = cmp_le;
         ACT_GT:  cmp_flag = !cmp_le;
         default: cmp_flag = cmp_ge;
      endcase
      sq_rem2  = {sq_rem_ff[32:0], sq_val_ff[63:62]};
      sq_trial = {1'b0, sq_res_ff, 2'b01};
      cur_c    = c_ff[k_ff];
      mag_c    = cur_c[COMP_W-1] ? SQ_W'(-$signed(cur_c)) : SQ_W'(cur_c);
      mag      = MAG_W'({mag_c, {FRAC_BITS{1'b0}}}) + MAG_W'(s_ff >> 1);
      mag_ext  = DW'(mag);
      limit    = {s_ff, 32'd0};
      dt       = {drem_ff, dlo_ff[31]};
      qv       = $signed({36'd0, dlo_ff});
      if (dneg_ff) begin
         qv = -qv;
      end
      q_s = sat32(qv);
   end

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      ph_in         = ph_ff;
      neg_in        = mneg;
      tgt_in        = mtgt;
      pvld_in       = mvld;
      c_in          = c_ff;
      s_in          = s_ff;
      r2_in         = r2_ff;
      res_r_in      = res_r_ff;
      res_scalar_in = res_scalar_ff;
      res_flag_in   = res_flag_ff;
      res_status_in = res_status_ff;
      sq_val_in     = sq_val_ff;
      sq_rem_in     = sq_rem_ff;
      sq_res_in     = sq_res_ff;
      cnt_in        = cnt_ff;
      k_in          = k_ff;
      drem_in       = drem_ff;
      dlo_in        = dlo_ff;
      dneg_in       = dneg_ff;
      out_vld_in    = out_vld_ff && !rsp_ready;
      out_in        = out_ff;
      q_pop         = 1'b0;

      if (pvld_ff) begin
         unique case (tgt_ff)
            TGT_S:   s_in  = acc[SQ_W-1:0];
            TGT_R2:  r2_in = acc[63:0];
            default: c_in[tgt_ff[1:0]] = acc[COMP_W-1:0];
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (!q_st.empty) begin
               if (q_item.kind == KIND_SIMPLE) begin
                  if (out_free) begin
                     q_pop      = 1'b1;
                     out_in     = simple_res;
                     out_vld_in = 1'b1;
                  end
               end else begin
                  q_pop         = 1'b1;
                  item_in       = q_item;
                  ph_in         = '0;
                  res_r_in      = '0;
                  res_scalar_in = '0;
                  res_flag_in   = 1'b0;
                  res_status_in = ST_OK;
                  state_in      = S_MULT;
               end
            end
         end
         S_MULT: begin
            if (ph_ff == nph) begin
               state_in = S_EVAL;
            end else begin
               ph_in = ph_ff + 3'd1;
            end
         end
         S_EVAL: begin
            state_in = S_FIN;
            unique case (item_ff.kind)
               KIND_MUL: begin
                  for (int j = 0; j < 4; j++) begin
                     res_r_in[j] = rnd_s[j].val;
                     if (rnd_s[j].ovf) begin
                        res_status_in = ST_SAT;
                     end
                  end
               end
               KIND_SQN: begin
                  if (sqn_v > (SQ_W + 1)'(SCALAR_MAX)) begin
                     res_scalar_in = SCALAR_MAX;
                     res_status_in = ST_SAT;
                  end else begin
                     res_scalar_in = sqn_v[SCALAR_W-1:0];
                  end
               end
               KIND_CMP: res_flag_in = cmp_flag;
               KIND_NORM: begin
                  if (s_ff[SQ_W-1]) begin
                     res_scalar_in = SCALAR_W'(64'd1 << 32);
                  end else begin
                     sq_val_in = s_ff[63:0];
                     sq_rem_in = '0;
                     sq_res_in = '0;
                     cnt_in    = '0;
                     state_in  = S_SQRT;
                  end
               end
               KIND_DIV, KIND_INV: begin
                  if (s_ff == '0) begin
                     res_status_in = ST_ZDIV;
                  end else begin
                     k_in     = '0;
                     state_in = S_DLOAD;
                  end
               end
               default: ;
            endcase
         end
         S_SQRT: begin
            sq_val_in = {sq_val_ff[61:0], 2'b00};
            if (sq_rem2 >= sq_trial) begin
               sq_rem_in = 34'(sq_rem2 - sq_trial);
               sq_res_in = {sq_res_ff[30:0], 1'b1};
            end else begin
               sq_rem_in = sq_rem2[33:0];
               sq_res_in = {sq_res_ff[30:0], 1'b0};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               res_scalar_in = SCALAR_W'(sq_res_in);
               state_in      = S_FIN;
            end
         end
         S_DLOAD: begin
            if (mag_ext >= limit) begin
               res_r_in[k_ff] = cur_c[COMP_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
               res_status_in  = ST_SAT;
               k_in           = k_ff + 2'd1;
               state_in       = (k_ff == 2'd3) ? S_FIN : S_DLOAD;
            end else begin
               drem_in  = SQ_W'(mag_ext >> 32);
               dlo_in   = mag_ext[31:0];
               dneg_in  = cur_c[COMP_W-1];
               cnt_in   = '0;
               state_in = S_DITER;
            end
         end
         S_DITER: begin
            if (dt >= {1'b0, s_ff}) begin
               drem_in = SQ_W'(dt - {1'b0, s_ff});
               dlo_in  = {dlo_ff[30:0], 1'b1};
            end else begin
               drem_in = dt[SQ_W-1:0];
               dlo_in  = {dlo_ff[30:0], 1'b0};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = S_DDONE;
            end
         end
         S_DDONE: begin
            res_r_in[k_ff] = q_s.val;
            if (q_s.ovf) begin
               res_status_in = ST_SAT;
            end
            k_in     = k_ff + 2'd1;
            state_in = (k_ff == 2'd3) ? S_FIN : S_DLOAD;
         end
         S_FIN: begin
            if (out_free) begin
               out_in.r      = res_r_ff;
               out_in.scalar = res_scalar_ff;
               out_in.flag   = res_flag_ff;
               out_in.status = res_status_ff;
               out_vld_in    = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         pvld_ff    <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pvld_ff    <= pvld_in;
         out_vld_ff <= out_vld_in;
      end
      item_ff       <= item_in;
      ph_ff         <= ph_in;
      prod_ff       <= prod_in;
      neg_ff        <= neg_in;
      tgt_ff        <= tgt_in;
      c_ff          <= c_in;
      s_ff          <= s_in;
      r2_ff         <= r2_in;
      res_r_ff      <= res_r_in;
      res_scalar_ff <= res_scalar_in;
      res_flag_ff   <= res_flag_in;
      res_status_ff <= res_status_in;
      sq_val_ff     <= sq_val_in;
      sq_rem_ff     <= sq_rem_in;
      sq_res_ff     <= sq_res_in;
      cnt_ff        <= cnt_in;
      k_ff          <= k_in;
      drem_ff       <= drem_in;
      dlo_ff        <= dlo_in;
      dneg_ff       <= dneg_in;
      out_ff        <= out_in;
   end

endmodule

// ----- src/quaternion_alu.sv -----
// ----------------------------------------------------------------------------
// Quaternion ALU
// Quaternion arithmetic on signed fixed-point operands with saturation.
// ----------------------------------------------------------------------------
// Add, subtract, negate, conjugate, equal and not-equal complete at one item
// per cycle while the back end is idle and the receiver is ready. Other
// operations run in the back end one at a time: the Hamilton product, the
// squared norm and the comparisons use the four-lane multiplier; the norm
// then runs the bit-serial square root; division and inverse then run the
// bit-serial divider, which runs 32 steps per component. A queue in front of
// the back end keeps taking items while a long operation runs, and results
// leave in request order.
module quaternion_alu #(
   parameter int FRAC_BITS   = qalu_pkg::FRAC_BITS_DEF,
   parameter int QUEUE_DEPTH = qalu_pkg::QUEUE_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [3:0]   req_tuser,  // action
   input  logic [287:0] req_tdata,  // a_w a_x a_y a_z b_w b_x b_y b_z radius
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [183:0] rsp_tdata   // r_w r_x r_y r_z scalar flag status
);
   import qalu_pkg::*;

   queue_status_type q_st;
   back_status_type  back_st;
   item_type         push_item, head_item;
   logic             q_push;
   logic             q_pop;
   result_type       res;

   qalu_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .q_st       (q_st),
      .q_push     (q_push),
      .q_item     (push_item)
   );

   qalu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .item_in  (push_item),
      .pop      (q_pop),
      .item_out (head_item),
      .q_st     (q_st)
   );

   qalu_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_item    (head_item),
      .q_st      (q_st),
      .q_pop     (q_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_res   (res),
      .st        (back_st)
   );

   assign rsp_tdata = {3'b000, res.status, res.flag, res.scalar, res.r};

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[180:179] != 2'b11)
      else $error("status code out of range");

   a_flag_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[178] |-> rsp_tdata[177:0] == '0)
      else $error("flag result carries other fields");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      back_st.pop |-> !q_st.empty)
      else $error("pop from empty queue");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      back_st.pop |-> !back_st.busy)
      else $error("pop while back end busy");

endmodule

// ----- tb/sv/quaternion_alu_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Quaternion ALU checker
// Watches both stream channels, works out the expected result of every
// accepted request and compares each response transfer against it in order.
// ----------------------------------------------------------------------------
module quaternion_alu_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [3:0]   req_tuser,
   input  logic [287:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [183:0] rsp_tdata,
   output int           errors,
   output int           pending
);
   import qalu_pkg::*;

   typedef logic signed [129:0] wide_type;
   typedef logic [3:0][129:0] quad_type;

   typedef struct packed {
      logic [3:0][31:0] r;
      logic [49:0]      scalar;
      logic             flag;
      logic [1:0]       status;
   } answer_type;

   answer_type expected_answers[$];

   localparam wide_type Q_MAX = 130'sd2147483647;
   localparam wide_type Q_MIN = -130'sd2147483648;

   function automatic logic [31:0] clamp32(input wide_type v, inout logic ovf);
      if (v > Q_MAX) begin
         ovf = 1'b1;
         return 32'h7FFF_FFFF;
      end else if (v < Q_MIN) begin
         ovf = 1'b1;
         return 32'h8000_0000;
      end
      return v[31:0];
   endfunction

   function automatic quad_type widen(input logic [3:0][31:0] q);
      quad_type w;
      for (int i = 0; i < 4; i++) w[i] = wide_type'($signed(q[i]));
      return w;
   endfunction

   function automatic wide_type sum_sq(input quad_type q);
      wide_type s;
      s = 0;
      for (int i = 0; i < 4; i++) s = s + $signed(q[i]) * $signed(q[i]);
      return s;
   endfunction

   function automatic quad_type hamilton(input quad_type x, input quad_type y);
      quad_type c;
      wide_type x0, x1, x2, x3, y0, y1, y2, y3;
      x0 = x[0]; x1 = x[1]; x2 = x[2]; x3 = x[3];
      y0 = y[0]; y1 = y[1]; y2 = y[2]; y3 = y[3];
      c[0] = x0 * y0 - x1 * y1 - x2 * y2 - x3 * y3;
      c[1] = x0 * y1 + x1 * y0 + x2 * y3 - x3 * y2;
      c[2] = x0 * y2 + x2 * y0 + x3 * y1 - x1 * y3;
      c[3] = x0 * y3 + x3 * y0 + x1 * y2 - x2 * y1;
      return c;
   endfunction

   // Quotient num * conj(den) / |den|^2, rounded half away from zero.
   function automatic answer_type quotient(input quad_type num, input quad_type den);
      answer_type res;
      quad_type cj, p;
      wide_type s, half, n, mag, q;
      logic ovf;
      res = '0;
      ovf = 1'b0;
      s = sum_sq(den);
      if (s == 0) begin
         res.status = ST_ZDIV;
         return res;
      end
      cj[0] = den[0];
      for (int i = 1; i < 4; i++) cj[i] = -$signed(den[i]);
      p = hamilton(num, cj);
      half = s >>> 1;
      for (int i = 0; i < 4; i++) begin
         n = $signed(p[i]) <<< 16;
         mag = (n < 0) ? -n : n;
         q = (mag + half) / s;
         res.r[i] = clamp32((n < 0) ? -q : q, ovf);
      end
      res.status = ovf ? ST_SAT : ST_OK;
      return res;
   endfunction

   function automatic answer_type predict_answer(input logic [3:0] op,
                                                 input logic [3:0][31:0] qa,
                                                 input logic [3:0][31:0] qb,
                                                 input logic [31:0] rad);
      answer_type res;
      quad_type a, b, c, one;
      wide_type s, r2, t, root, probe;
      logic ovf;
      res = '0;
      ovf = 1'b0;
      a = widen(qa);
      b = widen(qb);
      case (op)
         ACT_ADD, ACT_SUB: begin
            for (int i = 0; i < 4; i++)
               res.r[i] = clamp32(op == ACT_ADD ? $signed(a[i]) + $signed(b[i])
                                                : $signed(a[i]) - $signed(b[i]), ovf);
         end
         ACT_MUL: begin
            c = hamilton(a, b);
            for (int i = 0; i < 4; i++)
               res.r[i] = clamp32(($signed(c[i]) + 130'sd32768) >>> 16, ovf);
         end
         ACT_DIV: res = quotient(a, b);
         ACT_NEG, ACT_CONJ: begin
            for (int i = 0; i < 4; i++)
               res.r[i] = clamp32((op == ACT_CONJ && i == 0) ? $signed(a[i])
                                                             : -$signed(a[i]), ovf);
         end
         ACT_INV: begin
            one = '0;
            one[0] = 130'sd65536;
            res = quotient(one, a);
         end
         ACT_SQNORM: begin
            t = (sum_sq(a) + 130'sd32768) >>> 16;
            if (t > wide_type'(SCALAR_MAX)) begin
               res.scalar = SCALAR_MAX;
               ovf = 1'b1;
            end else begin
               res.scalar = t[49:0];
            end
         end
         ACT_NORM: begin
            s = sum_sq(a);
            if (s >= (130'sd1 <<< 64)) begin
               res.scalar = 50'd1 << 32;
            end else begin
               root = 0;
               for (int i = 32; i >= 0; i--) begin
                  probe = root | (130'sd1 <<< i);
                  if (probe * probe <= s) root = probe;
               end
               res.scalar = root[49:0];
            end
         end
         ACT_EQ, ACT_NE: res.flag = ((qa == qb) == (op == ACT_EQ));
         ACT_LT, ACT_LE, ACT_GT, ACT_GE: begin
            s = sum_sq(a);
            r2 = wide_type'($signed(rad)) * wide_type'($signed(rad));
            case (op)
               ACT_LT:  res.flag = s < r2;
               ACT_LE:  res.flag = s <= r2;
               ACT_GT:  res.flag = s > r2;
               default: res.flag = s >= r2;
            endcase
         end
         default: ;
      endcase
      if (ovf) res.status = ST_SAT;
      return res;
   endfunction

   assign pending = expected_answers.size();

   initial errors = 0;

   always @(posedge clock) begin
      answer_type got, want;
      if (!reset) begin
         if (req_tvalid && req_tready)
            expected_answers.push_back(predict_answer(req_tuser, req_tdata[127:0],
                                                      req_tdata[255:128],
                                                      req_tdata[287:256]));
         if (rsp_tvalid && rsp_tready) begin
            got.r = rsp_tdata[127:0];
            got.scalar = rsp_tdata[177:128];
            got.flag = rsp_tdata[178];
            got.status = rsp_tdata[180:179];
            if (expected_answers.size() == 0) begin
               $display("%0t: response transfer with nothing expected, got %h",
                        $time, rsp_tdata);
               errors++;
            end else begin
               want = expected_answers.pop_front();
               for (int i = 0; i < 4; i++)
                  if (got.r[i] !== want.r[i]) begin
                     $display("%0t: r[%0d] expected %h actual %h",
                              $time, i, want.r[i], got.r[i]);
                     errors++;
                  end
               if (got.scalar !== want.scalar) begin
                  $display("%0t: scalar expected %h actual %h",
                           $time, want.scalar, got.scalar);
                  errors++;
               end
               if (got.flag !== want.flag) begin
                  $display("%0t: flag expected %b actual %b", $time, want.flag, got.flag);
                  errors++;
               end
               if (got.status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, got.status);
                  errors++;
               end
            end
         end
      end
   end

endmodule

// ----- tb/sv/quaternion_alu_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Quaternion ALU testbench
// Drives directed corner cases and then random operations through the ALU
// under three idling patterns, including a long response stall; the checker
// predicts and compares every response.
// ----------------------------------------------------------------------------
module quaternion_alu_tb;
   import qalu_pkg::*;

   localparam logic [3:0] ACT_UNUSED = 4'd15;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int PHASE_ITEMS = 366;
   localparam logic [31:0] Q_ONE = 32'h0001_0000;
   localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] Q_MIN = 32'h8000_0000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [3:0]   req_tuser = '0;
   logic [287:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [183:0] rsp_tdata;
   int           errors;
   int           pending;
   int           tx_idle_pct = 0;
   int           rx_idle_pct = 0;
   int           cycles = 0;
   logic         hold_go = 1'b0;
   logic         hold_seen = 1'b0;
   int           hold_left = 0;

   quaternion_alu dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   quaternion_alu_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .errors(errors), .pending(pending)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // A toggle of hold_go starts a long stretch with the receiver not ready.
   always @(posedge clock) begin
      if (hold_go != hold_seen) begin
         hold_seen <= hold_go;
         hold_left <= 400;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   task automatic send(input logic [3:0] op, input logic [3:0][31:0] a,
                       input logic [3:0][31:0] b, input logic [31:0] rad);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {rad, b, a};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_part();
      case ($urandom_range(4))
         0: return $urandom();
         1: return 32'($urandom_range(32'h3FFFF)) - 32'h20000;
         2: return 32'($signed($urandom()) >>> $urandom_range(24, 4));
         3: begin
            case ($urandom_range(4))
               0: return Q_MAX;
               1: return Q_MIN;
               2: return Q_ONE;
               3: return -Q_ONE;
               default: return '0;
            endcase
         end
         default: return 32'($urandom_range(32'h1FFFFF));
      endcase
   endfunction

   function automatic logic [3:0][31:0] rand_quat();
      logic [3:0][31:0] q;
      for (int i = 0; i < 4; i++) q[i] = rand_part();
      if ($urandom_range(9) == 0) q = '0;
      return q;
   endfunction

   task automatic send_random();
      logic [3:0][31:0] a, b;
      logic [3:0] op;
      logic [31:0] rad;
      op = 4'($urandom_range(15));
      a = rand_quat();
      b = ($urandom_range(5) == 0) ? a : rand_quat();
      rad = rand_part();
      if ($urandom_range(3) == 0) begin
         // Sometimes take the radius from the upper half of a_w plus a small offset.
         rad = 32'($urandom_range(3)) + {16'd0, a[0][31:16]};
      end
      send(op, a, b, rad);
   endtask

   initial begin
      logic [3:0][31:0] big, low, one, zero, mix;
      big = {4{Q_MAX}};
      low = {4{Q_MIN}};
      one = {32'd0, 32'd0, 32'd0, Q_ONE};
      zero = '0;
      mix = {32'h0003_8000, 32'hFFFE_4000, 32'h0000_0001, 32'h0002_0000};

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send(ACT_ADD, big, big, '0);
      send(ACT_ADD, low, low, '0);
      send(ACT_SUB, low, big, '0);
      send(ACT_SUB, mix, one, '0);
      send(ACT_MUL, mix, mix, '0);
      send(ACT_MUL, low, low, '0);
      send(ACT_DIV, mix, one, '0);
      send(ACT_DIV, mix, zero, '0);
      send(ACT_DIV, one, {4{32'd1}}, '0);
      send(ACT_NEG, low, zero, '0);
      send(ACT_NEG, mix, zero, '0);
      send(ACT_CONJ, low, zero, '0);
      send(ACT_INV, zero, zero, '0);
      send(ACT_INV, mix, zero, '0);
      send(ACT_INV, {4{32'd1}}, zero, '0);
      send(ACT_SQNORM, low, zero, '0);
      send(ACT_NORM, low, zero, '0);
      send(ACT_NORM, mix, zero, '0);
      send(ACT_EQ, mix, mix, '0);
      send(ACT_NE, mix, one, '0);
      send(ACT_LT, one, zero, Q_ONE);
      send(ACT_LE, one, zero, -Q_ONE);
      send(ACT_GT, big, zero, Q_MIN);
      send(ACT_GE, zero, zero, '0);
      send(ACT_UNUSED, big, low, Q_MAX);
      drain();

      tx_idle_pct = 22;
      rx_idle_pct = 49;
      repeat (PHASE_ITEMS) send_random();
      drain();

      tx_idle_pct = 49;
      rx_idle_pct = 22;
      hold_go <= ~hold_go;
      repeat (PHASE_ITEMS) send_random();
      drain();

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      repeat (PHASE_ITEMS) send_random();
      drain();

      repeat (200) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ----- quaternion_alu.f -----
src/qalu_pkg.sv
src/qalu_front.sv
src/qalu_queue.sv
src/qalu_back.sv
src/quaternion_alu.sv
tb/sv/quaternion_alu_checker.sv
tb/sv/quaternion_alu_tb.sv
